/* sv/pointer_motion_shaper_unit_macros.svh */
// Assertion macros of the pointer motion shaper, included by its controller.
// Needs only a clock and an active-low reset at the place of use.
`ifndef POINTER_MOTION_SHAPER_UNIT_MACROS_SVH
`define POINTER_MOTION_SHAPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pointer motion shaper: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pointer motion shaper: next-cycle check failed");

`endif

/* sv/pms_pkg.sv */
// Shared types and constants of the pointer motion shaper.
// Used by the controller, the datapath and the top level; depends on nothing.
package pms_pkg;

  localparam int unsigned AccW           = 17;
  localparam int unsigned DivSteps       = 17;
  localparam int unsigned DivCntW        = $clog2(DivSteps);
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 8;
  localparam logic [6:0]  ClampLimit     = 7'd127;
  localparam logic [5:0]  ResetThreshold = 6'd6;
  localparam logic [7:0]  ResetDivisor   = 8'd24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDragScroll = 3'd0,
    CfgSniping    = 3'd1,
    CfgAccel      = 3'd2,
    CfgThreshold  = 3'd3,
    CfgDivisor    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic div_init_thr;
    logic div_step;
    logic take;
    logic mul;
    logic write;
    logic publish;
    logic lane;
    logic use_t;
  } cmd_t;

  typedef struct packed {
    logic drag;
    logic snipe;
    logic accel;
    logic over;
    logic big;
  } sts_t;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              move_valid;
    logic signed [7:0] scroll_h;
    logic              h_valid;
    logic signed [7:0] scroll_v;
    logic              v_valid;
  } res_t;

endpackage

/* sv/pms_if.sv */
// Valid/ready channel interfaces for motion samples and mouse reports.
// Self-contained; used by the top level of the pointer motion shaper.
interface pms_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;

  modport source (output valid, delta_x, delta_y, input ready);
  modport sink   (input valid, delta_x, delta_y, output ready);
endinterface

interface pms_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic              move_valid;
  logic signed [7:0] scroll_h;
  logic              h_valid;
  logic signed [7:0] scroll_v;
  logic              v_valid;

  modport source (output valid, move_x, move_y, move_valid, scroll_h, h_valid,
                  scroll_v, v_valid, input ready);
  modport sink   (input valid, move_x, move_y, move_valid, scroll_h, h_valid,
                  scroll_v, v_valid, output ready);
endinterface

/* sv/pointer_motion_shaper_unit.sv */
// Outside drag-scroll mode, acceleration lengthens the time from acceptance to report; in
// drag-scroll mode that time is set by the shared 17-step divider and the acceleration.
// One sample is handled at a time; the next is taken in the cycle after the report moves
// into the output register, and a waiting report does not stop the next sample.
// Reset clears the mode bits, both scroll accumulators and all handshake state, and
// restores the threshold to 6 and the acceleration divisor to 24.
module pointer_motion_shaper_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pms_in_if.sink                       motion_i,
  pms_out_if.source                    report_o,
  input  logic                         cfg_we_i,
  input  logic [pms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pms_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pms_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (motion_i.valid),
    .in_ready_o  (motion_i.ready),
    .out_valid_o (report_o.valid),
    .out_ready_i (report_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pms_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .delta_x_i   (motion_i.delta_x),
    .delta_y_i   (motion_i.delta_y),
    .res_o       (res)
  );

  assign report_o.move_x     = res.move_x;
  assign report_o.move_y     = res.move_y;
  assign report_o.move_valid = res.move_valid;
  assign report_o.scroll_h   = res.scroll_h;
  assign report_o.h_valid    = res.h_valid;
  assign report_o.scroll_v   = res.scroll_v;
  assign report_o.v_valid    = res.v_valid;

endmodule

/* sv/pms_datapath.sv */
// Datapath of the pointer motion shaper: configuration registers, scroll
// accumulators, a shared restoring divider, the squarer and result registers.
// Depends on pms_pkg.
module pms_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pms_pkg::cmd_t                cmd_i,
  output pms_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [pms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pms_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [15:0]           delta_x_i,
  input  logic signed [15:0]           delta_y_i,
  output pms_pkg::res_t                res_o
);
  import pms_pkg::*;

  logic                   drag_q, snipe_q, accel_q;
  logic [5:0]             thr_q;
  logic [7:0]             div_q;
  logic signed [AccW-1:0] acc_h_q, acc_v_q;
  logic signed [15:0]     dx_q, dy_q;
  logic [AccW-1:0]        mag_q, quo_q;
  logic                   neg_q;
  logic [7:0]             rem_q;
  logic                   dvs_sel_q;
  res_t                   res_q, out_q;

  logic [7:0]             thr_eff, div_eff, dvs;
  logic signed [AccW-1:0] sum_h, sum_v, src;
  logic [AccW-1:0]        src_mag;
  logic [8:0]             part, diff;
  logic                   ge;
  logic [13:0]            sq;
  logic [AccW:0]          shaped;
  logic [6:0]             clamp_mag;
  logic signed [7:0]      val;

  assign thr_eff = (thr_q == 6'd0) ? 8'd1 : {2'b00, thr_q};
  assign div_eff = (div_q == 8'd0) ? 8'd1 : div_q;
  assign dvs     = dvs_sel_q ? div_eff : thr_eff;

  assign sum_h = acc_h_q + {dx_q[15], dx_q};
  assign sum_v = acc_v_q - {dy_q[15], dy_q};

  always_comb begin
    if (cmd_i.lane) begin
      src = drag_q ? sum_v : {dy_q[15], dy_q};
    end else begin
      src = drag_q ? sum_h : {dx_q[15], dx_q};
    end
  end

  assign src_mag = src[AccW-1] ? AccW'(-src) : AccW'(src);

  assign part = {rem_q, quo_q[AccW-1]};
  assign ge   = part >= {1'b0, dvs};
  assign diff = part - {1'b0, dvs};
  assign sq   = mag_q[6:0] * mag_q[6:0];

  assign shaped    = cmd_i.use_t ? ({1'b0, quo_q} + {1'b0, mag_q}) : {1'b0, mag_q};
  assign clamp_mag = (shaped > {{(AccW-6){1'b0}}, ClampLimit}) ? ClampLimit : shaped[6:0];
  assign val       = neg_q ? -$signed({1'b0, clamp_mag}) : $signed({1'b0, clamp_mag});

  assign sts_o.drag  = drag_q;
  assign sts_o.snipe = snipe_q;
  assign sts_o.accel = accel_q;
  assign sts_o.over  = src_mag > {{(AccW-8){1'b0}}, thr_eff};
  assign sts_o.big   = |mag_q[AccW-1:7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q  <= 1'b0;
      snipe_q <= 1'b0;
      accel_q <= 1'b0;
      thr_q   <= ResetThreshold;
      div_q   <= ResetDivisor;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDragScroll: drag_q  <= cfg_wdata_i[0];
        CfgSniping:    snipe_q <= cfg_wdata_i[0];
        CfgAccel:      accel_q <= cfg_wdata_i[0];
        CfgThreshold:  thr_q   <= cfg_wdata_i[5:0];
        CfgDivisor:    div_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // An accumulator is cleared when its magnitude passes the threshold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_h_q <= '0;
      acc_v_q <= '0;
    end else if (cmd_i.load && drag_q) begin
      if (cmd_i.lane) begin
        acc_v_q <= sts_o.over ? '0 : sum_v;
      end else begin
        acc_h_q <= sts_o.over ? '0 : sum_h;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q  <= delta_x_i;
      dy_q  <= delta_y_i;
      res_q <= '0;
    end
    if (cmd_i.load) begin
      mag_q <= src_mag;
      neg_q <= src[AccW-1];
    end
    if (cmd_i.take) begin
      mag_q <= quo_q;
    end
    if (cmd_i.div_init_thr) begin
      quo_q     <= mag_q;
      rem_q     <= '0;
      dvs_sel_q <= 1'b0;
    end
    if (cmd_i.mul) begin
      quo_q     <= {{(AccW-14){1'b0}}, sq};
      rem_q     <= '0;
      dvs_sel_q <= 1'b1;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[7:0] : part[7:0];
      quo_q <= {quo_q[AccW-2:0], ge};
    end
    if (cmd_i.write) begin
      if (drag_q) begin
        if (cmd_i.lane) begin
          res_q.scroll_v <= val;
          res_q.v_valid  <= 1'b1;
        end else begin
          res_q.scroll_h <= val;
          res_q.h_valid  <= 1'b1;
        end
      end else begin
        if (cmd_i.lane) begin
          res_q.move_y <= val;
        end else begin
          res_q.move_x <= val;
        end
        res_q.move_valid <= 1'b1;
      end
    end
    if (cmd_i.publish) begin
      out_q <= res_q;
    end
  end

  assign res_o = out_q;

endmodule

/* sv/pms_ctrl.sv */
// Controller of the pointer motion shaper: sequences the two lanes of a
// sample through load, divide, square and write steps. Depends on pms_pkg.
module pms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pms_pkg::sts_t sts_i,
  output pms_pkg::cmd_t cmd_o
);
  import pms_pkg::*;

  `include "pointer_motion_shaper_unit_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_DIVSET = 8'b0000_0100,
    S_DIVRUN = 8'b0000_1000,
    S_TAKE   = 8'b0001_0000,
    S_SHAPE  = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_WRITE  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic               finish_q, finish_d;
  logic               lane_q, lane_d;
  logic               phase_q, phase_d;
  logic               use_t_q, use_t_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    finish_d     = finish_q;
    lane_d       = lane_q;
    phase_d      = phase_q;
    use_t_d      = use_t_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    cmd_o        = '0;
    cmd_o.lane   = lane_q;
    cmd_o.use_t  = use_t_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish_q) begin
      // The finished report waits here until the output register is free.
      if (!out_valid_q || out_ready_i) begin
        cmd_o.publish = 1'b1;
        out_valid_d   = 1'b1;
        finish_d      = 1'b0;
        state_d       = S_IDLE;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            lane_d        = 1'b0;
            state_d       = S_LOAD;
          end
        end
        S_LOAD: begin
          cmd_o.load = 1'b1;
          use_t_d    = 1'b0;
          if (sts_i.drag && !sts_i.over) begin
            if (!lane_q) begin
              lane_d  = 1'b1;
              state_d = S_LOAD;
            end else begin
              finish_d = 1'b1;
            end
          end else if (sts_i.drag) begin
            state_d = S_DIVSET;
          end else begin
            state_d = S_SHAPE;
          end
        end
        S_DIVSET: begin
          cmd_o.div_init_thr = 1'b1;
          cnt_d              = '0;
          phase_d            = 1'b0;
          state_d            = S_DIVRUN;
        end
        S_DIVRUN: begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_d = phase_q ? S_WRITE : S_TAKE;
          end
        end
        S_TAKE: begin
          cmd_o.take = 1'b1;
          state_d    = S_SHAPE;
        end
        S_SHAPE: begin
          if (sts_i.accel && !sts_i.big && (sts_i.drag || !sts_i.snipe)) begin
            state_d = S_MUL;
          end else begin
            state_d = S_WRITE;
          end
        end
        S_MUL: begin
          cmd_o.mul = 1'b1;
          cnt_d     = '0;
          phase_d   = 1'b1;
          use_t_d   = 1'b1;
          state_d   = S_DIVRUN;
        end
        S_WRITE: begin
          cmd_o.write = 1'b1;
          if (!lane_q) begin
            lane_d  = 1'b1;
            state_d = S_LOAD;
          end else begin
            finish_d = 1'b1;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      finish_q    <= 1'b0;
      lane_q      <= 1'b0;
      phase_q     <= 1'b0;
      use_t_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      finish_q    <= finish_d;
      lane_q      <= lane_d;
      phase_q     <= phase_d;
      use_t_q     <= use_t_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !finish_q;
  assign out_valid_o = out_valid_q;

  `PMS_ASSERT_NEXT(a_accept_starts_lane0, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_LOAD && !lane_q)
  `PMS_ASSERT_NEXT(a_last_write_finishes, clk_i, rst_ni, !finish_q && state_q == S_WRITE && lane_q, finish_q)
  `PMS_ASSERT_NEXT(a_blocked_finish_holds, clk_i, rst_ni, finish_q && out_valid_q && !out_ready_i, finish_q && out_valid_q)
  `PMS_ASSERT_SAME(a_div_count_bound, clk_i, rst_ni, state_q == S_DIVRUN, cnt_q <= DivCntW'(DivSteps - 1))

endmodule

/* tb/sv/pms_report_checker.sv */
// Report checker for the pointer motion shaper: predicts one report per motion transfer.
// Depends on pms_pkg and the channel interfaces in pms_if.sv.
`timescale 1ns / 100ps
module pms_report_checker
  import pms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pms_in_if                   motion_i,
  pms_out_if                  report_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  reports_o
);

  logic              drag_q;
  logic              snipe_q;
  logic              accel_q;
  logic [5:0]        thr_q;
  logic [7:0]        div_q;
  logic signed [16:0] acc_h;
  logic signed [16:0] acc_v;
  res_t              report_q[$];
  res_t              want;

  function automatic longint clip(input longint v);
    if (v > longint'(ClampLimit)) return longint'(ClampLimit);
    if (v < -longint'(ClampLimit)) return -longint'(ClampLimit);
    return v;
  endfunction

  function automatic longint accelerate(input longint q);
    longint d;
    if (!accel_q) return clip(q);
    d = (div_q == 8'd0) ? 1 : longint'(div_q);
    if (q > 0) return clip(q * q / d + q);
    return clip(-((q * q) / d) + q);
  endfunction

  // Updates the scroll accumulators as a side effect.
  function automatic res_t predict_report(input logic signed [15:0] dx,
                                          input logic signed [15:0] dy);
    res_t   r;
    longint thr;
    longint ah;
    longint av;
    r = '0;
    if (drag_q) begin
      thr = (thr_q == 6'd0) ? 1 : longint'(thr_q);
      ah  = longint'(acc_h) + longint'(dx);
      av  = longint'(acc_v) - longint'(dy);
      if (((ah < 0) ? -ah : ah) > thr) begin
        r.scroll_h = 8'(accelerate(ah / thr));
        r.h_valid  = 1'b1;
        ah = 0;
      end
      if (((av < 0) ? -av : av) > thr) begin
        r.scroll_v = 8'(accelerate(av / thr));
        r.v_valid  = 1'b1;
        av = 0;
      end
      acc_h = 17'(ah);
      acc_v = 17'(av);
    end else if (snipe_q) begin
      r.move_x     = 8'(clip(longint'(dx)));
      r.move_y     = 8'(clip(longint'(dy)));
      r.move_valid = 1'b1;
    end else begin
      r.move_x     = 8'(accelerate(longint'(dx)));
      r.move_y     = 8'(accelerate(longint'(dy)));
      r.move_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [8:0] exp_v,
                             input logic signed [8:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q    = 1'b0;
      snipe_q   = 1'b0;
      accel_q   = 1'b0;
      thr_q     = ResetThreshold;
      div_q     = ResetDivisor;
      acc_h     = '0;
      acc_v     = '0;
      report_q.delete();
      errors_o  = 0;
      pending_o = 0;
      reports_o = 0;
    end else begin
      if (report_i.valid && report_i.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: report transfer with no motion sample outstanding", $time);
          errors_o++;
        end else begin
          want = report_q.pop_front();
          check_field("move_x", want.move_x, report_i.move_x);
          check_field("move_y", want.move_y, report_i.move_y);
          check_field("move_valid", {8'd0, want.move_valid}, {8'd0, report_i.move_valid});
          check_field("scroll_h", want.scroll_h, report_i.scroll_h);
          check_field("h_valid", {8'd0, want.h_valid}, {8'd0, report_i.h_valid});
          check_field("scroll_v", want.scroll_v, report_i.scroll_v);
          check_field("v_valid", {8'd0, want.v_valid}, {8'd0, report_i.v_valid});
          reports_o++;
        end
      end
      if (motion_i.valid && motion_i.ready) begin
        report_q.push_back(predict_report(motion_i.delta_x, motion_i.delta_y));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDragScroll: drag_q  = cfg_wdata_i[0];
          CfgSniping:    snipe_q = cfg_wdata_i[0];
          CfgAccel:      accel_q = cfg_wdata_i[0];
          CfgThreshold:  thr_q   = cfg_wdata_i[5:0];
          CfgDivisor:    div_q   = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = report_q.size();
    end
  end

endmodule

/* tb/sv/pointer_motion_shaper_unit_tb.sv */
// Top of the pointer motion shaper testbench: clock, reset, register set-up and traffic.
// Depends on pms_pkg, pms_if.sv, the block itself and pms_report_checker.
`timescale 1ns / 100ps
module pointer_motion_shaper_unit_tb
  import pms_pkg::*;
;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int                  errors;
  int                  pending;
  int                  reports;
  int                  samples_sent = 0;
  int                  settings_loaded = 0;
  bit                  idle_on = 1'b1;
  bit                  hold_req = 1'b0;

  pms_in_if  motion_ch ();
  pms_out_if report_ch ();

  pointer_motion_shaper_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .motion_i    (motion_ch),
    .report_o    (report_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pms_report_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .motion_i    (motion_ch),
    .report_i    (report_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .reports_o   (reports)
  );

  always #6 clk_i = ~clk_i;

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Unused upper data bits carry noise, and one write goes to an unmapped index.
  task automatic load_settings(input bit drag, input bit snipe, input bit accel,
                               input logic [5:0] thr, input logic [7:0] div);
    put_reg(CfgDragScroll, {7'($urandom), drag});
    put_reg(CfgSniping, {7'($urandom), snipe});
    put_reg(CfgAccel, {7'($urandom), accel});
    put_reg(CfgThreshold, {2'($urandom), thr});
    put_reg(CfgDivisor, div);
    put_reg(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, CfgDivisor + 1)), 8'($urandom));
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_motion(input logic signed [15:0] dx, input logic signed [15:0] dy);
    if (idle_on && $urandom_range(2) == 0) begin
      motion_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    motion_ch.valid   <= 1'b1;
    motion_ch.delta_x <= dx;
    motion_ch.delta_y <= dy;
    @(posedge clk_i);
    while (!motion_ch.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic drain_reports();
    motion_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'(int'($urandom_range(40)) - 20);
      4, 5:       return 16'(int'($urandom_range(600)) - 300);
      6, 7:       return 16'($urandom);
      8: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default:    return 16'(int'($urandom_range(160)) - 80);
    endcase
  endfunction

  function automatic logic [5:0] pick_threshold();
    case ($urandom_range(4))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd63;
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [7:0] pick_divisor();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin : report_sink
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        report_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (idle_on && $urandom_range(3) == 0) begin
        report_ch.ready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk_i);
      end
      report_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    bit drag;
    bit snipe;
    bit accel;
    motion_ch.valid   <= 1'b0;
    motion_ch.delta_x <= '0;
    motion_ch.delta_y <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_wdata_i       <= '0;
    rst_ni            <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings straight out of reset: normal mode, clamp only.
    send_motion(16'sh7fff, 16'sh8000);
    send_motion(16'sd127, -16'sd127);
    send_motion(16'sd128, -16'sd128);
    send_motion(16'sd0, -16'sd1);
    drain_reports();

    // Acceleration with a zero divisor, which behaves as one.
    load_settings(1'b0, 1'b0, 1'b1, 6'd6, 8'd0);
    send_motion(16'sd1, -16'sd1);
    send_motion(16'sd10, -16'sd10);
    send_motion(16'sd11, -16'sd11);
    send_motion(16'sh8000, 16'sh7fff);
    drain_reports();

    load_settings(1'b0, 1'b0, 1'b1, 6'd6, 8'd255);
    send_motion(16'sd15, -16'sd16);
    send_motion(16'sd16, -16'sd15);
    send_motion(16'sd127, -16'sd127);
    drain_reports();

    // Sniping ignores acceleration.
    load_settings(1'b0, 1'b1, 1'b1, 6'd6, 8'd24);
    send_motion(16'sd200, -16'sd200);
    send_motion(16'sh8000, 16'sh7fff);
    drain_reports();

    // Drag-scroll with a zero threshold, which behaves as one.
    load_settings(1'b1, 1'b0, 1'b0, 6'd0, 8'd24);
    send_motion(16'sd1, 16'sd1);
    send_motion(16'sd1, -16'sd1);
    send_motion(16'sh7fff, 16'sh8000);
    send_motion(16'sd0, 16'sd0);
    drain_reports();

    // Drag-scroll takes priority over sniping; largest threshold.
    load_settings(1'b1, 1'b1, 1'b1, 6'd63, 8'd24);
    send_motion(16'sd63, -16'sd63);
    send_motion(16'sd1, 16'sd0);
    send_motion(16'sh8000, 16'sh7fff);
    send_motion(-16'sd64, 16'sd64);
    drain_reports();

    for (int p = 0; p < 10; p++) begin
      drag  = ($urandom_range(4) < 2);
      snipe = 1'($urandom);
      accel = 1'($urandom);
      idle_on = (p < 8);
      if (p == 2) hold_req = 1'b1;
      load_settings(drag, snipe, accel, pick_threshold(), pick_divisor());
      repeat (50) send_motion(rand_delta(), rand_delta());
      drain_reports();
    end

    repeat (90) @(posedge clk_i);
    $display("Sent %0d motion samples under %0d register settings; %0d reports compared.",
             samples_sent, settings_loaded, reports);
    $display("Modes: normal, accelerated, sniping and drag-scroll, incl. zero/max settings.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
